>>> hdl/double_ended_queue_core_macros.svh
// Assertion macros shared by the double-ended queue modules.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("double-ended queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("double-ended queue assertion failed");

`endif

>>> hdl/deq_pkg.sv
// Types and constants shared by the double-ended queue modules.
`timescale 1ns / 1ps
package deq_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DUMP       = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    push_back;
        logic    push_front;
        logic    pop_back;
        logic    pop_front;
        logic    dump_start;
        logic    rd_en;
        logic    idx_inc;
        logic    dump_load;
        logic    res_load;
        t_status res_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic out_free;
        logic dump_last;
    } t_sts;

endpackage

>>> hdl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/deq_ctrl.sv
// Controller state machine of the double-ended queue.
`timescale 1ns / 1ps
`include "double_ended_queue_core_macros.svh"
module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  deq_pkg::t_op  i_operation,
    output logic          o_in_ready,
    input  deq_pkg::t_sts i_sts,
    output deq_pkg::t_cmd o_cmd
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;
    logic   in_accept;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cmd      = cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_operation)
                        OP_PUSH_BACK: begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = i_sts.full ? ST_FULL : ST_OK;
                            cmd.push_back  = !i_sts.full;
                        end
                        OP_PUSH_FRONT: begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = i_sts.full ? ST_FULL : ST_OK;
                            cmd.push_front = !i_sts.full;
                        end
                        OP_POP_BACK: begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = i_sts.empty ? ST_EMPTY : ST_OK;
                            cmd.pop_back   = !i_sts.empty;
                        end
                        OP_POP_FRONT: begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = i_sts.empty ? ST_EMPTY : ST_OK;
                            cmd.pop_front  = !i_sts.empty;
                        end
                        OP_DUMP: begin
                            if (i_sts.empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                cmd.dump_start = 1'b1;
                                n_state        = S_READ;
                            end
                        end
                        default: begin
                            // Undefined operations are taken and dropped.
                        end
                    endcase
                end
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    cmd.dump_load = 1'b1;
                    if (i_sts.dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        n_state     = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `DEQ_ASSERT_SAME(a_accept_idle, i_clk, i_rst_n, in_accept, r_state == S_IDLE)
    `DEQ_ASSERT_SAME(a_one_update, i_clk, i_rst_n, 1'b1,
        $onehot0({cmd.push_back, cmd.push_front, cmd.pop_back, cmd.pop_front, cmd.dump_start}))
    `DEQ_ASSERT_SAME(a_dump_load_free, i_clk, i_rst_n, cmd.dump_load,
        (r_state == S_SEND) && i_sts.out_free && !cmd.res_load)

endmodule

>>> hdl/deq_dp.sv
// Datapath of the double-ended queue: pointers, entry store and result register.
`timescale 1ns / 1ps
`include "double_ended_queue_core_macros.svh"
module deq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    input  deq_pkg::t_cmd                    i_cmd,
    output deq_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [deq_pkg::STATUS_W-1:0]     o_status,
    output logic [deq_pkg::POS_W-1:0]        o_position,
    output logic signed [deq_pkg::DATA_W-1:0] o_entry_value,
    output logic                             o_last
);
    import deq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = PW + 1;

    logic [PW-1:0] r_front;
    logic [CW-1:0] r_count;
    logic [PW-1:0] r_idx;

    logic                     r_valid;
    t_status                  r_status;
    logic [POS_W-1:0]         r_position;
    logic signed [DATA_W-1:0] r_entry_value;
    logic                     r_last;

    logic [SW-1:0] back_sum;
    logic [SW-1:0] dump_sum;
    logic [PW-1:0] back_slot;
    logic [PW-1:0] dump_slot;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] front_inc;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [DATA_W-1:0] rd_data;

    // Offsets from the front stay below twice the depth, so one subtract wraps them.
    assign back_sum  = SW'(r_front) + SW'(r_count);
    assign dump_sum  = SW'(r_front) + SW'(r_idx);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? PW'(back_sum - SW'(DEPTH)) : PW'(back_sum);
    assign dump_slot = (dump_sum >= SW'(DEPTH)) ? PW'(dump_sum - SW'(DEPTH)) : PW'(dump_sum);
    assign front_dec = (r_front == '0) ? PW'(DEPTH - 1) : r_front - PW'(1);
    assign front_inc = (r_front == PW'(DEPTH - 1)) ? '0 : r_front + PW'(1);

    assign wr_en   = i_cmd.push_back || i_cmd.push_front;
    assign wr_addr = i_cmd.push_front ? front_dec : back_slot;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (dump_slot),
        .o_rd_data (rd_data)
    );

    assign o_sts.full      = (r_count == CW'(DEPTH));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.out_free  = !r_valid || i_out_ready;
    assign o_sts.dump_last = ((CW'(r_idx) + CW'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push_back) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.push_front) begin
                r_front <= front_dec;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_back) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.pop_front) begin
                r_front <= front_inc;
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_start) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.res_load || i_cmd.dump_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status      <= i_cmd.res_status;
            r_position    <= '0;
            r_entry_value <= '0;
            r_last        <= 1'b1;
        end else if (i_cmd.dump_load) begin
            r_status      <= ST_OK;
            r_position    <= POS_W'(r_idx);
            r_entry_value <= rd_data;
            r_last        <= o_sts.dump_last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_entry_value = r_entry_value;
    assign o_last        = r_last;

    `DEQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `DEQ_ASSERT_SAME(a_front_bound, i_clk, i_rst_n, 1'b1, SW'(r_front) < SW'(DEPTH))
    `DEQ_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, i_cmd.push_back || i_cmd.push_front,
        r_count == $past(r_count) + CW'(1))

endmodule

>>> hdl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Input channel: i_in_valid / o_in_ready carry an operation code and a value.
// Operations are push back, push front, pop back, pop front and dump; other
// codes are taken and dropped without a result.
// Output channel: o_out_valid / i_out_ready carry status, position, entry
// value and a last mark on the final result of each input transfer.
// A push or pop gives one result, held in the result register from the cycle after its transfer;
// with the receiver taking every result, one push or pop is accepted per
// cycle. A dump streams the stored entries front to back, one at a time: each
// entry is read from the registered entry store in S_READ and placed in the
// result register in S_SEND once that register is free, and input is held off
// until the last entry has been placed in the result register; an empty dump
// gives a single empty-status result.
// Reset leaves the queue empty with the front at slot zero; the store itself
// is not cleared, and no entry is read before it has been written.
// When the receiver stalls, the result register holds its contents and input
// is refused until the pending result is taken or taken in the same cycle.
`timescale 1ns / 1ps
module double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [deq_pkg::OP_W-1:0]          i_operation,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [deq_pkg::STATUS_W-1:0]      o_status,
    output logic [deq_pkg::POS_W-1:0]         o_position,
    output logic signed [deq_pkg::DATA_W-1:0] o_entry_value,
    output logic                              o_last
);
    import deq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (t_op'(i_operation)),
        .o_in_ready  (o_in_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_value (o_entry_value),
        .o_last        (o_last)
    );

endmodule

>>> tb/double_ended_queue_core_tb.sv
// Self-checking testbench for the double-ended queue core: directed and random operations.
`timescale 1ns / 1ps
module double_ended_queue_core_tb;
    import deq_pkg::*;

    localparam int DEPTH            = 16;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 152;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 40;
    localparam int REPORT_LINES     = 40;

    // Codes outside the operation set; the core takes them and gives no result.
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        t_status                   status;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  entry_value;
        logic                      last;
    } t_deq_result;

    class deq_scoreboard;
        logic signed [DATA_W-1:0] slots [DEPTH];
        logic [POS_W-1:0]         front = '0;
        logic [POS_W:0]           count = '0;
        t_deq_result              expected_q [$];
        int mismatches   = 0;
        int results_seen = 0;
        int full_seen    = 0;
        int empty_seen   = 0;
        int dumped_seen  = 0;
        int spare_seen   = 0;

        // Works out the results of one accepted input transfer and updates the queue copy.
        function void note_input(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
            t_deq_result      r;
            logic [POS_W-1:0] slot;
            int               i;
            r.status      = ST_OK;
            r.position    = '0;
            r.entry_value = '0;
            r.last        = 1'b1;
            case (op)
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                    if (count == DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        if (op == OP_PUSH_BACK) begin
                            slot = front + count[POS_W-1:0];
                        end else begin
                            front = front - 1'b1;
                            slot  = front;
                        end
                        slots[slot] = val;
                        count++;
                    end
                    expected_q.push_back(r);
                end
                OP_POP_BACK, OP_POP_FRONT: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        if (op == OP_POP_FRONT) front = front + 1'b1;
                        count--;
                    end
                    expected_q.push_back(r);
                end
                OP_DUMP: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                        expected_q.push_back(r);
                    end else begin
                        for (i = 0; i < count; i++) begin
                            slot          = front + i[POS_W-1:0];
                            r.position    = i[POS_W-1:0];
                            r.entry_value = slots[slot];
                            r.last        = (i == count - 1);
                            expected_q.push_back(r);
                        end
                    end
                end
                default: begin
                    spare_seen++;
                end
            endcase
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= REPORT_LINES) $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_result(t_deq_result got);
            t_deq_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("result with none expected (status %0d pos %0d value %0d)",
                                 got.status, got.position, got.entry_value));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.position !== want.position)
                report($sformatf("position %0d, expected %0d", got.position, want.position));
            if (got.entry_value !== want.entry_value)
                report($sformatf("entry value %0d, expected %0d",
                                 got.entry_value, want.entry_value));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_EMPTY) empty_seen++;
            if (want.status == ST_OK && (want.position != 0 || want.last == 1'b0)) dumped_seen++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic [OP_W-1:0]           i_operation = '0;
    logic signed [DATA_W-1:0]  i_value     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic [POS_W-1:0]          o_position;
    logic signed [DATA_W-1:0]  o_entry_value;
    logic                      o_last;

    deq_scoreboard sb;
    t_deq_result   seen;
    int            send_idle_pct   = 0;
    int            recv_idle_pct   = 0;
    int            hold_cycles_req = 0;
    int            hold_left       = 0;
    int            cycle_count     = 0;
    bit            fill_bias       = 1'b1;

    double_ended_queue_core #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_value (o_entry_value),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[double_ended_queue_core] ERROR");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_cycles_req != 0) begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            seen.status      = t_status'(o_status);
            seen.position    = o_position;
            seen.entry_value = o_entry_value;
            seen.last        = o_last;
            sb.check_result(seen);
        end
    end

    // Offers one item, with random idle cycles first, and returns in the step of its transfer.
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_input(op, val);
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        int                       done;
        int                       r;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        done = 0;
        while (done < n) begin
            // The bias swings the queue between filling and emptying.
            if ($urandom_range(39) == 0) fill_bias = !fill_bias;
            r = $urandom_range(99);
            if (r < 3) begin
                op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            end else begin
                if (r < 11)
                    op = OP_DUMP;
                else if (r < (fill_bias ? 66 : 44))
                    op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else
                    op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                done++;
            end
            case ($urandom_range(7))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = '0;
                3:       val = -1;
                default: val = $urandom;
            endcase
            send_item(op, val);
        end
    endtask

    initial begin
        int i;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 17;
        recv_idle_pct = 81;
        send_item(OP_POP_BACK, -1);
        send_item(OP_POP_FRONT, -1);
        send_item(OP_DUMP, -1);
        send_item(OP_PUSH_BACK, 32'sh8000_0000);
        send_item(OP_PUSH_FRONT, 32'sh7fff_ffff);
        send_item(OP_PUSH_BACK, '0);
        send_item(OP_PUSH_FRONT, -1);
        for (i = 0; i < DEPTH - 4; i++)
            send_item(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
        send_item(OP_PUSH_BACK, 32'sh1234_5678);
        send_item(OP_PUSH_FRONT, 32'sh5a5a_5a5a);
        send_item(OP_DUMP, '0);
        send_item(OP_SPARE_FIRST, 32'sh7fff_ffff);
        send_item(OP_SPARE_LAST, -1);
        send_item(OP_POP_BACK, '0);
        send_item(OP_POP_FRONT, '0);
        drain();

        run_random(RANDOM_PER_PHASE);
        drain();

        send_idle_pct = 81;
        recv_idle_pct = 17;
        run_random(RANDOM_PER_PHASE);
        drain();

        // No idling, but the receiver first holds off long enough for input to back up.
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_cycles_req = HOLD_CYCLES;
        run_random(RANDOM_PER_PHASE);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results still expected at the end", sb.pending()));

        $display("Checked %0d results: %0d dumped entries, %0d full and %0d empty statuses.",
                 sb.results_seen, sb.dumped_seen, sb.full_seen, sb.empty_seen);
        $display("%0d spare codes dropped; three idle mixes and a %0d-cycle receiver hold-off.",
                 sb.spare_seen, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("[double_ended_queue_core] OK");
        else
            $display("[double_ended_queue_core] ERROR");
        $finish;
    end

endmodule
